FILE: hdl/assert_macros.svh
// Shared concurrent assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hdl/lce_pkg.sv
package lce_pkg;

  localparam int LARGE_INPUTS = 6;
  localparam int PAIR_INPUTS  = 6;
  localparam int SMALL_MAX    = 5;

  localparam int RED_W    = LARGE_INPUTS - 1;
  localparam int COMBOS   = 2 ** RED_W;
  localparam int LARGE_TW = 2 ** LARGE_INPUTS;
  localparam int SMALL_TW = 2 ** SMALL_MAX;

  typedef logic [2:0] status_t;

  localparam status_t ST_PASS       = 3'd0;
  localparam status_t ST_BAD_COUNTS = 3'd1;
  localparam status_t ST_BAD_SPLIT  = 3'd2;
  localparam status_t ST_NOT_SHARED = 3'd3;
  localparam status_t ST_MISMATCH   = 3'd4;

  typedef logic [SMALL_MAX-1:0][2:0] pos_vec_t;

  typedef struct packed {
    logic    ok;
    status_t status;
  } precheck_t;

endpackage

FILE: hdl/lce_precheck.sv
module lce_precheck (
  input  logic [3:0]        pair_input_count,
  input  logic [2:0]        large_count,
  input  logic [2:0]        small_count,
  input  logic [2:0]        split_position,
  input  lce_pkg::pos_vec_t small_pos,
  output lce_pkg::precheck_t chk
);
  import lce_pkg::*;

  logic       bad_counts;
  logic       bad_split;
  logic [2:0] red_count;
  logic [SMALL_MAX-1:0] unshared;

  assign bad_counts = (pair_input_count != 4'(PAIR_INPUTS)) || (large_count == 3'd0) ||
                      (large_count > 3'(LARGE_INPUTS)) || (small_count == 3'd0) ||
                      (small_count > 3'(SMALL_MAX));
  assign bad_split  = (split_position >= large_count);
  assign red_count  = large_count - 3'd1;

  always_comb begin
    for (int i = 0; i < SMALL_MAX; i++) begin
      unshared[i] = (3'(i) < small_count) && (small_pos[i] >= red_count);
    end
  end

  always_comb begin
    if (bad_counts) begin
      chk.status = ST_BAD_COUNTS;
    end else if (bad_split) begin
      chk.status = ST_BAD_SPLIT;
    end else if (|unshared) begin
      chk.status = ST_NOT_SHARED;
    end else begin
      chk.status = ST_PASS;
    end
    chk.ok = (chk.status == ST_PASS);
  end

endmodule

FILE: hdl/lce_cofactor.sv
module lce_cofactor (
  input  logic [lce_pkg::SMALL_TW-1:0] truth_small,
  input  logic [lce_pkg::LARGE_TW-1:0] truth_large,
  input  logic [2:0]                   large_count,
  input  logic [2:0]                   small_count,
  input  logic [2:0]                   split_position,
  input  lce_pkg::pos_vec_t            small_pos,
  output logic                         mismatch
);
  import lce_pkg::*;

  logic [COMBOS-1:0]       diff;
  logic [LARGE_INPUTS-1:0] limit;
  logic [LARGE_INPUTS-1:0] low_mask;

  assign limit    = LARGE_INPUTS'(1) << (large_count - 3'd1);
  assign low_mask = (LARGE_INPUTS'(1) << split_position) - LARGE_INPUTS'(1);

  for (genvar c = 0; c < COMBOS; c++) begin : g_combo
    localparam logic [RED_W-1:0] CV = RED_W'(c);
    logic [LARGE_INPUTS-1:0] ext;
    logic [LARGE_INPUTS-1:0] addr_large;
    logic [SMALL_MAX-1:0]    addr_small;

    assign ext        = {1'b0, CV};
    assign addr_large = (((ext >> split_position) << split_position) << 1) | (ext & low_mask);

    always_comb begin
      for (int i = 0; i < SMALL_MAX; i++) begin
        addr_small[i] = (3'(i) < small_count) && (small_pos[i] < 3'(RED_W)) &&
                        CV[small_pos[i]];
      end
    end

    assign diff[c] = (ext < limit) && (truth_small[addr_small] != truth_large[addr_large]);
  end

  assign mismatch = |diff;

endmodule

FILE: hdl/lut_cofactor_equivalence_check_unit.sv
// LUT cofactor equivalence check unit.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. busy stays low, so one LUT pair can be issued every cycle.
// Fields: both truth tables, the pair input count, the large and small input
// counts, the split position and the five reduced small-input positions.
// Result channel: out_valid is high for exactly one cycle with out_equivalent
// and out_status; the transaction completes at the edge that ends that cycle.
// A pair taken is held in the input registers, its result in the result
// registers. Throughput: one pair per cycle, set by the single combinational
// compare of all 32 cofactor combinations between the input and result
// registers.
// Reset (rst_n low, synchronous) drops any pair in flight and clears
// out_valid. The receiver cannot stall; each result is shown once.
module lut_cofactor_equivalence_check_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [lce_pkg::SMALL_TW-1:0] in_truth_small,
  input  logic [lce_pkg::LARGE_TW-1:0] in_truth_large,
  input  logic [3:0]                   in_pair_input_count,
  input  logic [2:0]                   in_large_count,
  input  logic [2:0]                   in_small_count,
  input  logic [2:0]                   in_split_position,
  input  logic [2:0]                   in_small_pos0,
  input  logic [2:0]                   in_small_pos1,
  input  logic [2:0]                   in_small_pos2,
  input  logic [2:0]                   in_small_pos3,
  input  logic [2:0]                   in_small_pos4,
  output logic                         out_valid,
  output logic                         out_equivalent,
  output lce_pkg::status_t             out_status
);
  import lce_pkg::*;

  logic                valid_r;
  logic [SMALL_TW-1:0] truth_small_r;
  logic [LARGE_TW-1:0] truth_large_r;
  logic [3:0]          pair_r;
  logic [2:0]          large_count_r;
  logic [2:0]          small_count_r;
  logic [2:0]          split_r;
  pos_vec_t            pos_r;

  logic                out_valid_r;
  logic                out_equivalent_r;
  status_t             out_status_r;
  status_t             status_nxt;

  precheck_t           chk;
  logic                mismatch;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      truth_small_r <= in_truth_small;
      truth_large_r <= in_truth_large;
      pair_r        <= in_pair_input_count;
      large_count_r <= in_large_count;
      small_count_r <= in_small_count;
      split_r       <= in_split_position;
      pos_r         <= {in_small_pos4, in_small_pos3, in_small_pos2,
                        in_small_pos1, in_small_pos0};
    end
  end

  lce_precheck u_precheck (
    .pair_input_count (pair_r),
    .large_count      (large_count_r),
    .small_count      (small_count_r),
    .split_position   (split_r),
    .small_pos        (pos_r),
    .chk              (chk)
  );

  lce_cofactor u_cofactor (
    .truth_small    (truth_small_r),
    .truth_large    (truth_large_r),
    .large_count    (large_count_r),
    .small_count    (small_count_r),
    .split_position (split_r),
    .small_pos      (pos_r),
    .mismatch       (mismatch)
  );

  always_comb begin
    if (!chk.ok) begin
      status_nxt = chk.status;
    end else if (mismatch) begin
      status_nxt = ST_MISMATCH;
    end else begin
      status_nxt = ST_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_r) begin
      out_status_r     <= status_nxt;
      out_equivalent_r <= (status_nxt == ST_PASS);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_equivalent = out_equivalent_r;

endmodule

FILE: hdl/lce_checker.sv
`include "assert_macros.svh"

module lce_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [3:0]       in_pair_input_count,
  input logic             out_valid,
  input logic             out_equivalent,
  input lce_pkg::status_t out_status
);
  import lce_pkg::*;

  // transaction in gives a result on out_valid
  `ASSERT_NXT(a_latency, start && !busy, ##1 out_valid)

  // no result without an earlier transaction
  `ASSERT_IMP(a_no_spurious, out_valid, $past(start && !busy, 2))

  `ASSERT_IMP(a_equiv_status, out_valid, out_equivalent == (out_status == ST_PASS))

  // a pass needs the right pair input count
  `ASSERT_IMP(a_pass_pair, out_valid && out_status == ST_PASS,
              $past(in_pair_input_count, 2) == 4'(PAIR_INPUTS))

endmodule

bind lut_cofactor_equivalence_check_unit lce_checker u_lce_checker (.*);
